// ===== sv/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg - shared types and constants for the cron schedule matcher
// Entry layout, tick time bundle, request and result codes, FSM states.
// ----------------------------------------------------------------------------
`default_nettype none

package csm_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] SUNDAY_DOW = 4'd7;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_TICK   = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FULL  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_FINAL = 2'd2
    } t_state;

    // all-ones in a pattern field is the wildcard
    typedef struct packed {
        logic [6:0] minute;
        logic [5:0] hour;
        logic [5:0] mday;
        logic [4:0] month;
        logic [3:0] dow;
        logic [7:0] action;
    } t_entry;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] mday;
        logic [3:0] month;
        logic [2:0] wday;
    } t_now;

endpackage

`default_nettype wire

// ===== sv/cron_schedule_matcher.sv =====
// ----------------------------------------------------------------------------
// cron_schedule_matcher - ordered table of cron patterns with tick matching
//
// Input channel (i_in_valid / o_in_ready) carries one request: add a pattern,
// remove all equal patterns, or a clock tick with the current time. Output
// channel (o_out_valid / i_out_ready) returns results: one fired result per
// matching entry in table order on a tick, then a single result with o_last.
// Table lives in a 16-entry synchronous RAM (one read, one write port).
// Remove and tick walk the N entries held one entry per cycle through the RAM
// read port, while no tick hit is stalled on the output register. A new
// request is taken only in idle, but the last result may still sit in the
// output register when the next request is accepted.
// Receiver stall holds the output register; a tick scan freezes on a hit
// until the output register frees up.
// Reset clears the entry count and the control state; RAM contents are not
// cleared, only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module cron_schedule_matcher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic signed [6:0] i_pat_minute,
    input  wire logic signed [5:0] i_pat_hour,
    input  wire logic signed [5:0] i_pat_mday,
    input  wire logic signed [4:0] i_pat_month,
    input  wire logic signed [3:0] i_pat_dow,
    input  wire logic [7:0]  i_action_id,
    input  wire logic [5:0]  i_now_minute,
    input  wire logic [4:0]  i_now_hour,
    input  wire logic [4:0]  i_now_mday,
    input  wire logic [3:0]  i_now_month,
    input  wire logic [2:0]  i_now_wday,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_fired_action,
    output logic [csm_pkg::CNT_W-1:0] o_entry_count,
    output logic             o_last
);
    import csm_pkg::*;

    t_state             r_state, n_state;
    t_req               r_req, n_req;
    t_entry             r_pat, n_pat;
    t_now               r_now, n_now;
    t_kind              r_final_kind, n_final_kind;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [IDX_W-1:0]   r_wr, n_wr;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_out_valid, n_out_valid;
    t_kind              r_out_kind, n_out_kind;
    logic [7:0]         r_out_action, n_out_action;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic               r_out_last, n_out_last;

    t_entry             mem [TABLE_DEPTH];
    t_entry             r_rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry             mem_wdata;

    logic               in_acc;
    logic               out_free;
    logic               tick_match;
    logic               entry_eq;
    logic               scan_last;
    logic               scan_stall;
    logic               scan_go;
    logic [IDX_W-1:0]   idx_next;
    logic [3:0]         now_dow;
    logic [5:0]         now_month_1;
    t_entry             in_entry;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign in_entry = '{minute: i_pat_minute, hour: i_pat_hour, mday: i_pat_mday,
                        month: i_pat_month, dow: i_pat_dow, action: i_action_id};

    // pattern month is 1-based, tick month 0-based; Sunday 0 maps to 7
    assign now_dow     = (r_now.wday == 3'd0) ? SUNDAY_DOW : {1'b0, r_now.wday};
    assign now_month_1 = {2'b00, r_now.month} + 6'd1;

    always_comb begin
        tick_match = (&r_rd_data.minute || r_rd_data.minute == {1'b0, r_now.minute})
                  && (&r_rd_data.hour   || r_rd_data.hour   == {1'b0, r_now.hour})
                  && (&r_rd_data.mday   || r_rd_data.mday   == {1'b0, r_now.mday})
                  && (&r_rd_data.month  ||
                      {r_rd_data.month[4], r_rd_data.month} == now_month_1)
                  && (&r_rd_data.dow    || r_rd_data.dow    == now_dow);
    end

    assign entry_eq   = (r_rd_data == r_pat);
    assign idx_next   = r_idx + 1'b1;
    assign scan_last  = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign scan_stall = (r_state == S_SCAN) && (r_req == REQ_TICK) && tick_match
                     && !out_free;
    assign scan_go    = (r_state == S_SCAN) && !scan_stall;

    always_comb begin
        case (r_state)
            S_SCAN:  rd_addr = scan_go ? idx_next : r_idx;
            default: rd_addr = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if ((i_req_type == REQ_REMOVE || i_req_type == REQ_TICK)
                        && r_count != '0)
                        n_state = S_SCAN;
                    else
                        n_state = S_FINAL;
                end
            end
            S_SCAN: begin
                if (scan_go && scan_last)
                    n_state = S_FINAL;
            end
            S_FINAL: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_req        = r_req;
        n_pat        = r_pat;
        n_now        = r_now;
        n_final_kind = r_final_kind;
        n_idx        = r_idx;
        n_wr         = r_wr;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kind   = r_out_kind;
        n_out_action = r_out_action;
        n_out_count  = r_out_count;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = r_wr;
        mem_wdata    = r_rd_data;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_req        = t_req'(i_req_type);
                    n_pat        = in_entry;
                    n_now        = '{minute: i_now_minute, hour: i_now_hour,
                                     mday: i_now_mday, month: i_now_month,
                                     wday: i_now_wday};
                    n_idx        = '0;
                    n_wr         = '0;
                    n_final_kind = KIND_DONE;
                    if (i_req_type == REQ_ADD) begin
                        if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                            n_final_kind = KIND_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[IDX_W-1:0];
                            mem_wdata = in_entry;
                            n_count   = r_count + 1'b1;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan_go) begin
                    n_idx = idx_next;
                    if (r_req == REQ_TICK && tick_match) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_FIRED;
                        n_out_action = r_rd_data.action;
                        n_out_count  = r_count;
                        n_out_last   = 1'b0;
                    end
                    if (r_req == REQ_REMOVE) begin
                        // compaction: write slot never passes read slot
                        if (!entry_eq) begin
                            mem_we    = 1'b1;
                            mem_waddr = r_wr;
                            mem_wdata = r_rd_data;
                            n_wr      = r_wr + 1'b1;
                        end
                        if (scan_last)
                            n_count = CNT_W'(r_wr) + (entry_eq ? CNT_W'(0) : CNT_W'(1));
                    end
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_final_kind;
                    n_out_action = '0;
                    n_out_count  = r_count;
                    n_out_last   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_pat        <= n_pat;
        r_now        <= n_now;
        r_final_kind <= n_final_kind;
        r_idx        <= n_idx;
        r_wr         <= n_wr;
        r_out_kind   <= n_out_kind;
        r_out_action <= n_out_action;
        r_out_count  <= n_out_count;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_fired_action = r_out_action;
    assign o_entry_count  = r_out_count;
    assign o_last         = r_out_last;

    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_ADD && r_count < CNT_W'(TABLE_DEPTH))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted add did not grow the table");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_idx) < r_count))
        else $error("scan index past entry count");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_wr <= r_idx))
        else $error("compaction write slot overtook read slot");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && out_free) |=> (o_out_valid && o_last && r_state == S_IDLE))
        else $error("closing result not issued");

endmodule

`default_nettype wire
